/* rtl/ata_read_taskfile_builder_unit_macros.svh */
// assertion macros used by the task-file builder checker
`ifndef ATA_READ_TASKFILE_BUILDER_UNIT_MACROS_SVH
`define ATA_READ_TASKFILE_BUILDER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ATARTB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ATARTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/atartb_pkg.sv */
// types and constants of the ata read task-file builder
package atartb_pkg;

    localparam int ADDR_W     = 28;
    localparam int TGT_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int CYL_W      = 16;
    localparam int SPT_W      = 8;
    localparam int HC_W       = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // chs divider retires this many address bits per cycle unless a full queue stalls it
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = ADDR_W / DIV_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // task-file register targets, in emit order
    localparam logic [TGT_W-1:0] TGT_DRIVE_HEAD = 3'd0;
    localparam logic [TGT_W-1:0] TGT_CYL_HIGH   = 3'd1;
    localparam logic [TGT_W-1:0] TGT_CYL_LOW    = 3'd2;
    localparam logic [TGT_W-1:0] TGT_SECT_NUM   = 3'd3;
    localparam logic [TGT_W-1:0] TGT_SECT_CNT   = 3'd4;
    localparam logic [TGT_W-1:0] TGT_COMMAND    = 3'd5;

    // fixed register bytes
    localparam logic [BYTE_W-1:0] DH_BASE    = 8'hA0;
    localparam logic [BYTE_W-1:0] DRIVE1_BIT = 8'h10;
    localparam logic [BYTE_W-1:0] LBA_BIT    = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_READ   = 8'h21;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LBA_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS    = 2'd2;

    localparam logic [SPT_W-1:0] SPT_RESET = 8'd63;
    localparam logic [HC_W-1:0]  HC_RESET  = 5'd16;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic              drive_select;
        logic [BYTE_W-1:0] sector_total;
    } in_item_t;

    typedef struct packed {
        logic [TGT_W-1:0]  reg_target;
        logic [BYTE_W-1:0] reg_value;
        logic              final_write;
    } out_item_t;

    // decoded request passed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] dh_byte;
        logic [CYL_W-1:0]  cylinder;
        logic [BYTE_W-1:0] sector_num;
        logic [BYTE_W-1:0] sector_total;
    } task_t;

    typedef struct packed {
        logic             lba_mode;
        logic [SPT_W-1:0] sectors_per_track;
        logic [HC_W-1:0]  head_count;
    } cfg_t;

endpackage

/* rtl/atartb_fifo.sv */
// small queue of decoded requests between front and back
module atartb_fifo
    import atartb_pkg::*;
#(
    parameter int DEPTH = 2
)(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  task_t push_data,
    output logic  push_ready,
    input  logic  pop,
    output logic  head_valid,
    output task_t head
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    task_t             mem [DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;
    assign head       = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/atartb_front.sv */
// request intake and lba / chs address translation
module atartb_front
    import atartb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  cfg_t     cfg,
    output logic     push,
    output task_t    push_data,
    input  logic     q_ready
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [SPT_W-1:0]  rem1_reg, rem1_next;
    logic [HC_W-1:0]   rem2_reg, rem2_next;
    logic [CYL_W-1:0]  cyl_reg, cyl_next;
    logic              drive_reg;
    logic [BYTE_W-1:0] count_reg;

    logic [SPT_W-1:0]  div1;
    logic [HC_W-1:0]   div2;
    logic [SPT_W:0]    t1, d1;
    logic [HC_W:0]     t2, d2;
    logic              ge1, ge2;
    logic              accept, last, advance;
    task_t             lba_task, chs_task;

    // zero geometry counts as one
    assign div1 = (cfg.sectors_per_track == '0) ? SPT_W'(1) : cfg.sectors_per_track;
    assign div2 = (cfg.head_count == '0) ? HC_W'(1) : cfg.head_count;

    // two chained restoring dividers, quotient of the first feeds the second
    always_comb
    begin
        rem1_next = rem1_reg;
        rem2_next = rem2_reg;
        cyl_next  = cyl_reg;
        t1  = '0;
        d1  = '0;
        t2  = '0;
        d2  = '0;
        ge1 = 1'b0;
        ge2 = 1'b0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            t1        = {rem1_next, addr_reg[ADDR_W-1-k]};
            d1        = t1 - {1'b0, div1};
            ge1       = (t1 >= {1'b0, div1});
            rem1_next = ge1 ? d1[SPT_W-1:0] : t1[SPT_W-1:0];
            t2        = {rem2_next, ge1};
            d2        = t2 - {1'b0, div2};
            ge2       = (t2 >= {1'b0, div2});
            rem2_next = ge2 ? d2[HC_W-1:0] : t2[HC_W-1:0];
            cyl_next  = {cyl_next[CYL_W-2:0], ge2};
        end
    end

    // native lba split
    always_comb
    begin
        lba_task.dh_byte      = DH_BASE + (in_item.drive_select ? DRIVE1_BIT : '0)
                              + (LBA_BIT | {4'b0, in_item.block_address[ADDR_W-1:24]});
        lba_task.cylinder     = in_item.block_address[23:8];
        lba_task.sector_num   = in_item.block_address[7:0];
        lba_task.sector_total = in_item.sector_total;
    end

    // chs result from the final divider step
    always_comb
    begin
        chs_task.dh_byte      = DH_BASE + (drive_reg ? DRIVE1_BIT : '0)
                              + {{(BYTE_W-HC_W){1'b0}}, rem2_next};
        chs_task.cylinder     = cyl_next;
        chs_task.sector_num   = rem1_next + 8'd1;
        chs_task.sector_total = count_reg;
    end

    // handshake and queue push
    assign in_ready  = !busy_reg && q_ready;
    assign accept    = in_valid && in_ready;
    assign last      = busy_reg && (step_reg == STEP_W'(DIV_STEPS - 1));
    assign advance   = busy_reg && (!last || q_ready);
    assign push      = (accept && cfg.lba_mode) || (last && q_ready);
    assign push_data = busy_reg ? chs_task : lba_task;

    // divider sequencing
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept && !cfg.lba_mode)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (advance)
        begin
            step_next = step_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // working registers of the divider
    always_ff @(posedge clk)
    begin
        if (accept && !cfg.lba_mode)
        begin
            addr_reg  <= in_item.block_address;
            rem1_reg  <= '0;
            rem2_reg  <= '0;
            cyl_reg   <= '0;
            drive_reg <= in_item.drive_select;
            count_reg <= in_item.sector_total;
        end
        else if (advance)
        begin
            addr_reg <= addr_reg << DIV_BITS;
            rem1_reg <= rem1_next;
            rem2_reg <= rem2_next;
            cyl_reg  <= cyl_next;
        end
    end

endmodule

/* rtl/atartb_back.sv */
// register write sequencer with output register
module atartb_back
    import atartb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  task_t     q_head,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic [TGT_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;
    logic [BYTE_W-1:0] value;
    logic              slot_free, load, is_last;

    assign slot_free = !out_valid_reg || out_ready;
    assign load      = slot_free && q_valid;
    assign is_last   = (idx_reg == TGT_COMMAND);
    assign q_pop     = load && is_last;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // byte for the current target
    always_comb
    begin
        case (idx_reg)
            TGT_DRIVE_HEAD: value = q_head.dh_byte;
            TGT_CYL_HIGH:   value = q_head.cylinder[CYL_W-1:8];
            TGT_CYL_LOW:    value = q_head.cylinder[7:0];
            TGT_SECT_NUM:   value = q_head.sector_num;
            TGT_SECT_CNT:   value = q_head.sector_total;
            TGT_COMMAND:    value = CMD_READ;
            default:        value = '0;
        endcase
    end

    // next write and sequence position
    always_comb
    begin
        out_item_next.reg_target  = idx_reg;
        out_item_next.reg_value   = value;
        out_item_next.final_write = is_last;
        out_valid_next = slot_free ? q_valid : out_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            idx_next = is_last ? TGT_DRIVE_HEAD : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= TGT_DRIVE_HEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

/* rtl/ata_read_taskfile_builder_unit.sv */
// top level of the ata read task-file builder
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------
//  in       | in_valid / in_ready    | in_item (address, drive, count)
//  out      | out_valid / out_ready  | out_item (target, value, final)
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// each request yields six out transfers, one per cycle unless out stalls, set by the back sequencer
// lba mode: a request is queued in the cycle it is taken; the back sets the sustained rate
// chs mode: after intake, 7 divider steps of 4 address bits run before the next request is taken,
// which sets the sustained rate; the queue lets front and back overlap
// reset is asynchronous and active low; no clearing pass, config returns to defaults
// a stalled out transfer holds the output register; the front keeps working until the queue fills
module ata_read_taskfile_builder_unit
    import atartb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  q_push, q_push_ready, q_pop, q_valid;
    task_t q_push_data, q_head;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lba_mode          <= 1'b0;
            cfg_reg.sectors_per_track <= SPT_RESET;
            cfg_reg.head_count        <= HC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LBA_MODE: cfg_reg.lba_mode          <= cfg_data[0];
                CFG_SPT:      cfg_reg.sectors_per_track <= cfg_data[SPT_W-1:0];
                CFG_HEADS:    cfg_reg.head_count        <= cfg_data[HC_W-1:0];
                default:      ;
            endcase
        end
    end

    // request intake and translation
    atartb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg       (cfg_reg),
        .push      (q_push),
        .push_data (q_push_data),
        .q_ready   (q_push_ready)
    );

    // decoupling queue
    atartb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // register write sequencer
    atartb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

/* rtl/atartb_checker.sv */
// port-level checks of the task-file builder output sequence
`include "ata_read_taskfile_builder_unit_macros.svh"

module atartb_checker
    import atartb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // stalled write holds
    `ATARTB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled write changed")

    // final flag only on the command write
    `ATARTB_ASSERT_NOW(a_final_cmd, out_valid, out_item.final_write == (out_item.reg_target == TGT_COMMAND), "final flag misplaced")

    // command byte is read sectors
    `ATARTB_ASSERT_NOW(a_cmd_byte, out_valid && (out_item.reg_target == TGT_COMMAND), out_item.reg_value == CMD_READ, "wrong command byte")

    // writes of one request follow without gaps in target order
    `ATARTB_ASSERT_NEXT(a_seq_order, out_valid && out_ready && !out_item.final_write, out_valid && (out_item.reg_target == $past(out_item.reg_target) + 3'd1), "write sequence broken")

endmodule

bind ata_read_taskfile_builder_unit atartb_checker u_atartb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
